>>> src/bl_pkg.sv
// shared constants, types and codes for the bresenham line plotter
// no dependencies; used by every other file in src
package bl_pkg;

  // canvas side limit and the reach of the pixel fields
  localparam int MAX_SIDE   = 64;
  localparam int FIELD_SIDE = 64;
  localparam int SIDE_LIM   = (MAX_SIDE < FIELD_SIDE) ? MAX_SIDE : FIELD_SIDE;

  // field widths
  localparam int COORD_W    = 11;
  localparam int PIX_W      = 6;
  localparam int CODE_W     = 8;
  localparam int SIDE_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int CNT_W      = $clog2(SIDE_LIM);
  localparam int ERR_W      = PIX_W + 3;

  // register reset values
  localparam logic [CODE_W-1:0] BRUSH_RST  = 8'd42;
  localparam logic [SIDE_W-1:0] WIDTH_RST  = 7'd40;
  localparam logic [SIDE_W-1:0] HEIGHT_RST = 7'd15;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRUSH  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DRAW
  } state_t;

  // effective configuration seen by the sequencer
  typedef struct packed {
    logic [CODE_W-1:0] brush;
    logic [SIDE_W-1:0] width_lim;
    logic [SIDE_W-1:0] height_lim;
  } cfg_view_t;

  // operands of the shared step unit
  typedef struct packed {
    logic [PIX_W-1:0]        x;
    logic [PIX_W-1:0]        y;
    logic signed [ERR_W-1:0] err;
    logic [PIX_W-1:0]        dx;
    logic [PIX_W-1:0]        dy;
    logic                    x_neg;
    logic                    y_neg;
  } step_in_t;

  // result of one step
  typedef struct packed {
    logic [PIX_W-1:0]        x;
    logic [PIX_W-1:0]        y;
    logic signed [ERR_W-1:0] err;
  } step_out_t;

  // sequencer status for checking
  typedef struct packed {
    state_t state;
    logic   load;
    logic   load_last;
  } ctrl_stat_t;

endpackage

>>> src/bl_ifs.sv
// handshake channels of the line plotter: command, pixel word and config write
// depends on bl_pkg for widths
interface bl_cmd_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic signed [bl_pkg::COORD_W-1:0]   x_start;
  logic signed [bl_pkg::COORD_W-1:0]   y_start;
  logic signed [bl_pkg::COORD_W-1:0]   x_end;
  logic signed [bl_pkg::COORD_W-1:0]   y_end;

  modport source (output valid, mode, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, mode, x_start, y_start, x_end, y_end, output ready);
endinterface

interface bl_pix_if;
  logic                        valid;
  logic                        ready;
  logic [bl_pkg::PIX_W-1:0]    pixel_x;
  logic [bl_pkg::PIX_W-1:0]    pixel_y;
  logic [bl_pkg::CODE_W-1:0]   pixel_code;
  logic                        out_of_bounds;
  logic                        last;

  modport source (output valid, pixel_x, pixel_y, pixel_code, out_of_bounds, last,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_code, out_of_bounds, last,
                  output ready);
endinterface

interface bl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bl_pkg::CFG_IDX_W-1:0]    index;
  logic [bl_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/bl_cfg_regs.sv
// configuration registers: brush code and canvas size, with side saturation
// depends on bl_pkg and bl_cfg_if
module bl_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  bl_cfg_if.sink            cfg,
  output bl_pkg::cfg_view_t view
);

  logic [bl_pkg::CODE_W-1:0] brush;
  logic [bl_pkg::SIDE_W-1:0] width;
  logic [bl_pkg::SIDE_W-1:0] height;

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      brush  <= bl_pkg::BRUSH_RST;
      width  <= bl_pkg::WIDTH_RST;
      height <= bl_pkg::HEIGHT_RST;
    end else if (cfg.valid) begin
      unique case (bl_pkg::reg_idx_t'(cfg.index))
        bl_pkg::REG_BRUSH:  brush  <= cfg.data[bl_pkg::CODE_W-1:0];
        bl_pkg::REG_WIDTH:  width  <= cfg.data[bl_pkg::SIDE_W-1:0];
        bl_pkg::REG_HEIGHT: height <= cfg.data[bl_pkg::SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate canvas sides to the limit
  always_comb begin
    view.brush      = brush;
    view.width_lim  = (width > bl_pkg::SIDE_W'(bl_pkg::SIDE_LIM))
                      ? bl_pkg::SIDE_W'(bl_pkg::SIDE_LIM) : width;
    view.height_lim = (height > bl_pkg::SIDE_W'(bl_pkg::SIDE_LIM))
                      ? bl_pkg::SIDE_W'(bl_pkg::SIDE_LIM) : height;
  end

endmodule

>>> src/bl_step.sv
// shared bresenham step unit: one error update and coordinate move per use
// depends on bl_pkg
module bl_step (
  input  bl_pkg::step_in_t  si,
  output bl_pkg::step_out_t so
);

  logic signed [bl_pkg::ERR_W:0] e2;
  logic signed [bl_pkg::ERR_W:0] dxs;
  logic signed [bl_pkg::ERR_W:0] dys;
  logic signed [bl_pkg::ERR_W:0] err_sum;
  logic                          go_x;
  logic                          go_y;

  always_comb begin
    // doubled error against the deltas
    e2   = {si.err, 1'b0};
    dxs  = $signed({{(bl_pkg::ERR_W + 1 - bl_pkg::PIX_W){1'b0}}, si.dx});
    dys  = $signed({{(bl_pkg::ERR_W + 1 - bl_pkg::PIX_W){1'b0}}, si.dy});
    go_x = e2 > -dys;
    go_y = e2 < dxs;

    // error update
    err_sum = {si.err[bl_pkg::ERR_W-1], si.err}
              - (go_x ? dys : '0) + (go_y ? dxs : '0);
    so.err  = err_sum[bl_pkg::ERR_W-1:0];

    // coordinate moves
    if (go_x) begin
      so.x = si.x_neg ? si.x - bl_pkg::PIX_W'(1) : si.x + bl_pkg::PIX_W'(1);
    end else begin
      so.x = si.x;
    end
    if (go_y) begin
      so.y = si.y_neg ? si.y - bl_pkg::PIX_W'(1) : si.y + bl_pkg::PIX_W'(1);
    end else begin
      so.y = si.y;
    end
  end

endmodule

>>> src/bl_ctrl.sv
// sequencer: command capture, bounds check, line walk and output word register
// depends on bl_pkg, bl_ifs and the bl_step unit wired at the top level
module bl_ctrl (
  input  logic               clk,
  input  logic               rst,
  bl_cmd_if.sink             cmd,
  bl_pix_if.source           pix,
  input  bl_pkg::cfg_view_t  view,
  output bl_pkg::step_in_t   si,
  input  bl_pkg::step_out_t  so,
  output bl_pkg::ctrl_stat_t stat
);

  bl_pkg::state_t state, state_next;

  // captured command
  logic signed [bl_pkg::COORD_W-1:0] c_x0, c_y0, c_x1, c_y1;

  // walk registers
  logic [bl_pkg::PIX_W-1:0]        x, y, x1, y1, dx, dy;
  logic signed [bl_pkg::ERR_W-1:0] err;
  logic                            x_neg, y_neg;
  logic [bl_pkg::CNT_W-1:0]        cnt;

  // output word register
  logic                       o_valid;
  logic [bl_pkg::PIX_W-1:0]   o_x, o_y;
  logic [bl_pkg::CODE_W-1:0]  o_code;
  logic                       o_oob, o_last;

  logic accept, can_load, load, reject, setup, advance, at_end, in_ok;
  logic [bl_pkg::PIX_W-1:0] sx0, sy0, sx1, sy1, dx_c, dy_c;

  function automatic logic in_canvas(
    input logic signed [bl_pkg::COORD_W-1:0] px,
    input logic signed [bl_pkg::COORD_W-1:0] py,
    input logic [bl_pkg::SIDE_W-1:0]         w,
    input logic [bl_pkg::SIDE_W-1:0]         h
  );
    logic ok;
    ok = !px[bl_pkg::COORD_W-1] && !py[bl_pkg::COORD_W-1]
         && (px[bl_pkg::COORD_W-2:0] < (bl_pkg::COORD_W-1)'(w))
         && (py[bl_pkg::COORD_W-2:0] < (bl_pkg::COORD_W-1)'(h));
    return ok;
  endfunction

  // bounds check and walk setup from the captured command
  always_comb begin
    in_ok = in_canvas(c_x0, c_y0, view.width_lim, view.height_lim)
            && in_canvas(c_x1, c_y1, view.width_lim, view.height_lim);
    sx0   = c_x0[bl_pkg::PIX_W-1:0];
    sy0   = c_y0[bl_pkg::PIX_W-1:0];
    sx1   = c_x1[bl_pkg::PIX_W-1:0];
    sy1   = c_y1[bl_pkg::PIX_W-1:0];
    dx_c  = (sx1 > sx0) ? sx1 - sx0 : sx0 - sx1;
    dy_c  = (sy1 > sy0) ? sy1 - sy0 : sy0 - sy1;
  end

  // step unit operands
  always_comb begin
    si.x     = x;
    si.y     = y;
    si.err   = err;
    si.dx    = dx;
    si.dy    = dy;
    si.x_neg = x_neg;
    si.y_neg = y_neg;
  end

  // end of line: endpoint reached or point budget used up
  assign at_end = ((x == x1) && (y == y1))
                  || (cnt == bl_pkg::CNT_W'(bl_pkg::SIDE_LIM - 1));

  assign can_load = !o_valid || pix.ready;

  // next state and control
  always_comb begin
    state_next = state;
    cmd.ready  = 1'b0;
    load       = 1'b0;
    reject     = 1'b0;
    setup      = 1'b0;
    advance    = 1'b0;
    unique case (state)
      bl_pkg::S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) state_next = bl_pkg::S_CHECK;
      end
      bl_pkg::S_CHECK: begin
        if (!in_ok) begin
          if (can_load) begin
            load       = 1'b1;
            reject     = 1'b1;
            state_next = bl_pkg::S_IDLE;
          end
        end else begin
          setup      = 1'b1;
          state_next = bl_pkg::S_DRAW;
        end
      end
      bl_pkg::S_DRAW: begin
        if (can_load) begin
          load = 1'b1;
          if (at_end) state_next = bl_pkg::S_IDLE;
          else advance = 1'b1;
        end
      end
      default: state_next = bl_pkg::S_IDLE;
    endcase
  end

  assign accept = cmd.valid && cmd.ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= bl_pkg::S_IDLE;
    else state <= state_next;
  end

  // command capture; pixel mode ends where it starts
  always_ff @(posedge clk) begin
    if (accept) begin
      c_x0 <= cmd.x_start;
      c_y0 <= cmd.y_start;
      c_x1 <= cmd.mode ? cmd.x_end : cmd.x_start;
      c_y1 <= cmd.mode ? cmd.y_end : cmd.y_start;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (setup) begin
      x     <= sx0;
      y     <= sy0;
      x1    <= sx1;
      y1    <= sy1;
      dx    <= dx_c;
      dy    <= dy_c;
      x_neg <= !(sx0 < sx1);
      y_neg <= !(sy0 < sy1);
      err   <= $signed({3'b000, dx_c}) - $signed({3'b000, dy_c});
      cnt   <= '0;
    end else if (advance) begin
      x   <= so.x;
      y   <= so.y;
      err <= so.err;
      cnt <= cnt + bl_pkg::CNT_W'(1);
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) o_valid <= 1'b0;
    else if (load) o_valid <= 1'b1;
    else if (pix.ready) o_valid <= 1'b0;
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (reject) begin
        o_x    <= '0;
        o_y    <= '0;
        o_code <= '0;
        o_oob  <= 1'b1;
        o_last <= 1'b1;
      end else begin
        o_x    <= x;
        o_y    <= y;
        o_code <= view.brush;
        o_oob  <= 1'b0;
        o_last <= at_end;
      end
    end
  end

  assign pix.valid         = o_valid;
  assign pix.pixel_x       = o_x;
  assign pix.pixel_y       = o_y;
  assign pix.pixel_code    = o_code;
  assign pix.out_of_bounds = o_oob;
  assign pix.last          = o_last;

  // status for checking
  always_comb begin
    stat.state     = state;
    stat.load      = load;
    stat.load_last = reject || (state == bl_pkg::S_DRAW && at_end);
  end

endmodule

>>> src/bresenham_line_plotter.sv
// bresenham line plotter top level: config registers, sequencer, shared step unit
// the first word is loaded from the draw state, which follows the check state;
// a rejection word is loaded from the check state. A command holds the block until its final
// word is loaded, and any word may wait on the receiver
// the step unit gives one point per cycle while the receiver takes words
// reset: brush 42, canvas 40 by 15, sequencer idle, no word pending
module bresenham_line_plotter (
  input  logic     clk,
  input  logic     rst,
  bl_cmd_if.sink   cmd,
  bl_pix_if.source pix,
  bl_cfg_if.sink   cfg
);

  bl_pkg::cfg_view_t  view;
  bl_pkg::step_in_t   si;
  bl_pkg::step_out_t  so;
  bl_pkg::ctrl_stat_t stat;

  // configuration registers
  bl_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .view (view)
  );

  // shared step unit
  bl_step u_step (
    .si (si),
    .so (so)
  );

  // sequencer and output word register
  bl_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .pix  (pix),
    .view (view),
    .si   (si),
    .so   (so),
    .stat (stat)
  );

  // a rejected command is always a single final word
  a_oob_last: assert property (@(posedge clk) disable iff (rst)
    pix.valid && pix.out_of_bounds |-> pix.last)
    else $error("rejection word without last");

  // a taken command holds off the next one in the cycle after
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("command taken while busy");

  // loading the final word returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    stat.load && stat.load_last |=> stat.state == bl_pkg::S_IDLE)
    else $error("sequencer not idle after final word");

endmodule
